// File: rtl/cpsp_pkg.sv
// Shared types, constants and the microprogram of the cascaded position and speed PID core.
// Used by cpsp_datapath, cascaded_position_speed_pid_core and the testbench; depends on nothing else.
package cpsp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int GAIN_W = 31;
	localparam int SUM_W = 34;
	localparam int PROD_W = 63;
	localparam int ERR_SUM_BOUND_DEFAULT = 1000;

	localparam int UCODE_LEN = 18;
	localparam int STEP_W = $clog2(UCODE_LEN);

	localparam logic [GAIN_W-1:0] RST_OUTER_KP = 31'd0;
	localparam logic [GAIN_W-1:0] RST_OUTER_KI = 31'd0;
	localparam logic [GAIN_W-1:0] RST_OUTER_KD = 31'd0;
	localparam logic [GAIN_W-1:0] RST_INNER_KP = 31'd9175;
	localparam logic [GAIN_W-1:0] RST_INNER_KI = 31'd46;
	localparam logic [GAIN_W-1:0] RST_INNER_KD = 31'd655;
	localparam logic [GAIN_W-1:0] RST_SPEED_LIMIT = 31'd655360;
	localparam logic [GAIN_W-1:0] RST_TORQUE_LIMIT = 31'd65536;

	typedef enum logic [2:0] {
		REG_OUTER_KP,
		REG_OUTER_KI,
		REG_OUTER_KD,
		REG_INNER_KP,
		REG_INNER_KI,
		REG_INNER_KD,
		REG_SPEED_LIMIT,
		REG_TORQUE_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] outer_kp;
		logic [GAIN_W-1:0] outer_ki;
		logic [GAIN_W-1:0] outer_kd;
		logic [GAIN_W-1:0] inner_kp;
		logic [GAIN_W-1:0] inner_ki;
		logic [GAIN_W-1:0] inner_kd;
		logic [GAIN_W-1:0] speed_limit;
		logic [GAIN_W-1:0] torque_limit;
	} cfg_t;

	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_LD,
		ALU_ADD,
		ALU_SUB,
		ALU_SUB2,
		ALU_LDP,
		ALU_CLAMP
	} alu_op_t;

	typedef enum logic [3:0] {
		SRC_POS,
		SRC_SPD,
		SRC_TGT,
		SRC_E,
		SRC_D,
		SRC_OLE,
		SRC_OSUM,
		SRC_CMD,
		SRC_VE,
		SRC_ILE,
		SRC_IPE,
		SRC_IACC
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_E,
		DST_D,
		DST_OLE,
		DST_OSUM,
		DST_CMD,
		DST_VE,
		DST_ILE,
		DST_IPE,
		DST_IACC
	} dst_t;

	typedef enum logic [2:0] {
		G_OKP,
		G_OKI,
		G_OKD,
		G_IKP,
		G_IKI,
		G_IKD
	} gain_sel_t;

	typedef enum logic [1:0] {
		P_NONE,
		P_LOAD,
		P_ADD,
		P_ADDS
	} pacc_op_t;

	typedef enum logic [1:0] {
		LIM_INT,
		LIM_SPEED,
		LIM_TORQUE
	} lim_sel_t;

	typedef enum logic {
		SEQ_NEXT,
		SEQ_END
	} seq_t;

	typedef struct packed {
		alu_op_t   alu_op;
		logic      sat;
		src_t      alu_src;
		dst_t      dst;
		logic      mul_en;
		src_t      mul_src;
		gain_sel_t gain;
		pacc_op_t  pacc;
		lim_sel_t  lim;
		seq_t      seq;
	} ucode_t;

	// One control word per step: the outer loop in steps 0 to 7, the inner loop after it.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
		ucode_t w;
		w = '{ALU_NOP, 1'b0, SRC_E, DST_NONE, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT, SEQ_END};
		case (addr)
			5'd0: w = '{ALU_LD, 1'b0, SRC_TGT, DST_NONE, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT, SEQ_NEXT};
			5'd1: w = '{ALU_SUB, 1'b1, SRC_POS, DST_E, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT, SEQ_NEXT};
			5'd2: w = '{ALU_SUB, 1'b1, SRC_OLE, DST_D, 1'b1, SRC_E, G_OKP, P_NONE, LIM_INT, SEQ_NEXT};
			5'd3: w = '{ALU_LD, 1'b0, SRC_E, DST_OLE, 1'b1, SRC_OSUM, G_OKI, P_LOAD, LIM_INT,
				SEQ_NEXT};
			5'd4: w = '{ALU_ADD, 1'b1, SRC_OSUM, DST_NONE, 1'b1, SRC_D, G_OKD, P_ADDS, LIM_INT,
				SEQ_NEXT};
			5'd5: w = '{ALU_CLAMP, 1'b0, SRC_E, DST_OSUM, 1'b0, SRC_E, G_OKP, P_ADDS, LIM_INT,
				SEQ_NEXT};
			5'd6: w = '{ALU_LDP, 1'b0, SRC_E, DST_NONE, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT, SEQ_NEXT};
			5'd7: w = '{ALU_CLAMP, 1'b0, SRC_E, DST_CMD, 1'b0, SRC_E, G_OKP, P_NONE, LIM_SPEED,
				SEQ_NEXT};
			5'd8: w = '{ALU_SUB, 1'b1, SRC_SPD, DST_VE, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT, SEQ_NEXT};
			5'd9: w = '{ALU_SUB, 1'b1, SRC_ILE, DST_D, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT, SEQ_NEXT};
			5'd10: w = '{ALU_LD, 1'b0, SRC_VE, DST_NONE, 1'b1, SRC_D, G_IKP, P_NONE, LIM_INT,
				SEQ_NEXT};
			5'd11: w = '{ALU_SUB2, 1'b0, SRC_ILE, DST_NONE, 1'b1, SRC_VE, G_IKI, P_LOAD, LIM_INT,
				SEQ_NEXT};
			5'd12: w = '{ALU_ADD, 1'b1, SRC_IPE, DST_D, 1'b0, SRC_E, G_OKP, P_ADD, LIM_INT, SEQ_NEXT};
			5'd13: w = '{ALU_LD, 1'b0, SRC_ILE, DST_IPE, 1'b1, SRC_D, G_IKD, P_NONE, LIM_INT,
				SEQ_NEXT};
			5'd14: w = '{ALU_LD, 1'b0, SRC_VE, DST_ILE, 1'b0, SRC_E, G_OKP, P_ADD, LIM_INT, SEQ_NEXT};
			5'd15: w = '{ALU_LDP, 1'b1, SRC_E, DST_NONE, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT,
				SEQ_NEXT};
			5'd16: w = '{ALU_ADD, 1'b1, SRC_IACC, DST_NONE, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT,
				SEQ_NEXT};
			5'd17: w = '{ALU_CLAMP, 1'b0, SRC_E, DST_IACC, 1'b0, SRC_E, G_OKP, P_NONE, LIM_TORQUE,
				SEQ_END};
			default: w = '{ALU_NOP, 1'b0, SRC_E, DST_NONE, 1'b0, SRC_E, G_OKP, P_NONE, LIM_INT,
				SEQ_END};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/cpsp_datapath.sv
// Datapath of the PID core: operand registers, loop state, accumulator, shared multiplier.
// Driven by the sequencer with one control word per cycle in which en is high; depends on cpsp_pkg.
module cpsp_datapath import cpsp_pkg::*; #(
	parameter int ERR_SUM_BOUND = ERR_SUM_BOUND_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  ucode_t                   ctrl,
	input  logic                     en,
	input  logic                     load,
	input  logic signed [DATA_W-1:0] measured_position,
	input  logic signed [DATA_W-1:0] measured_speed,
	input  logic signed [DATA_W-1:0] target_position,
	output logic signed [DATA_W-1:0] speed_cmd,
	output logic signed [DATA_W-1:0] torque_next
);

	localparam logic signed [SUM_W-1:0] ILIM = SUM_W'(ERR_SUM_BOUND * (2 ** FRAC_BITS));
	localparam int QHI = FRAC_BITS + DATA_W - 1;

	logic signed [DATA_W-1:0] pos_q, spd_q, tgt_q;
	logic signed [DATA_W-1:0] e_q, d_q, cmd_q, ve_q;
	logic signed [DATA_W-1:0] ole_q, osum_q, ile_q, ipe_q, iacc_q;
	logic signed [SUM_W-1:0]  acc_q, psum_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [DATA_W-1:0] alu_val, mul_val, prod_sat, alu_sat, psum_sat;
	logic signed [SUM_W-1:0]  alu_ext, prod_ext, lim_val, alu_raw, acc_next, psum_sum;
	logic        [GAIN_W-1:0] gain_val;
	logic signed [63:0]       prod_full;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-DATA_W:0] hi;
		hi = v[SUM_W-1:DATA_W-1];
		if ((&hi) || !(|hi)) begin
			return v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] pick(input src_t s,
		input logic signed [DATA_W-1:0] pos, input logic signed [DATA_W-1:0] spd,
		input logic signed [DATA_W-1:0] tgt, input logic signed [DATA_W-1:0] e,
		input logic signed [DATA_W-1:0] d, input logic signed [DATA_W-1:0] ole,
		input logic signed [DATA_W-1:0] osum, input logic signed [DATA_W-1:0] cmd,
		input logic signed [DATA_W-1:0] ve, input logic signed [DATA_W-1:0] ile,
		input logic signed [DATA_W-1:0] ipe, input logic signed [DATA_W-1:0] iacc);
		logic signed [DATA_W-1:0] r;
		case (s)
			SRC_POS:  r = pos;
			SRC_SPD:  r = spd;
			SRC_TGT:  r = tgt;
			SRC_E:    r = e;
			SRC_D:    r = d;
			SRC_OLE:  r = ole;
			SRC_OSUM: r = osum;
			SRC_CMD:  r = cmd;
			SRC_VE:   r = ve;
			SRC_ILE:  r = ile;
			SRC_IPE:  r = ipe;
			SRC_IACC: r = iacc;
			default:  r = e;
		endcase
		return r;
	endfunction

	assign alu_val = pick(ctrl.alu_src, pos_q, spd_q, tgt_q, e_q, d_q, ole_q, osum_q, cmd_q,
		ve_q, ile_q, ipe_q, iacc_q);
	assign mul_val = pick(ctrl.mul_src, pos_q, spd_q, tgt_q, e_q, d_q, ole_q, osum_q, cmd_q,
		ve_q, ile_q, ipe_q, iacc_q);
	assign alu_ext = {{(SUM_W-DATA_W){alu_val[DATA_W-1]}}, alu_val};

	always_comb begin
		case (ctrl.gain)
			G_OKP:   gain_val = cfg.outer_kp;
			G_OKI:   gain_val = cfg.outer_ki;
			G_OKD:   gain_val = cfg.outer_kd;
			G_IKP:   gain_val = cfg.inner_kp;
			G_IKI:   gain_val = cfg.inner_ki;
			G_IKD:   gain_val = cfg.inner_kd;
			default: gain_val = cfg.outer_kp;
		endcase
	end

	always_comb begin
		case (ctrl.lim)
			LIM_INT:    lim_val = ILIM;
			LIM_SPEED:  lim_val = {{(SUM_W-GAIN_W){1'b0}}, cfg.speed_limit};
			LIM_TORQUE: lim_val = {{(SUM_W-GAIN_W){1'b0}}, cfg.torque_limit};
			default:    lim_val = ILIM;
		endcase
	end

	assign prod_full = $signed({1'b0, gain_val}) * mul_val;

	// The product is floored by the shift and then saturated to 32 bits.
	always_comb begin
		if ((&prod_q[PROD_W-1:QHI]) || !(|prod_q[PROD_W-1:QHI])) begin
			prod_sat = prod_q[QHI:FRAC_BITS];
		end else if (prod_q[PROD_W-1]) begin
			prod_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			prod_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	assign prod_ext = {{(SUM_W-DATA_W){prod_sat[DATA_W-1]}}, prod_sat};
	assign psum_sum = psum_q + prod_ext;
	assign psum_sat = sat32(psum_sum);

	always_comb begin
		case (ctrl.alu_op)
			ALU_NOP:  alu_raw = acc_q;
			ALU_LD:   alu_raw = alu_ext;
			ALU_ADD:  alu_raw = acc_q + alu_ext;
			ALU_SUB:  alu_raw = acc_q - alu_ext;
			ALU_SUB2: alu_raw = acc_q - (alu_ext <<< 1);
			ALU_LDP:  alu_raw = psum_q;
			ALU_CLAMP: begin
				if (acc_q > lim_val) begin
					alu_raw = lim_val;
				end else if (acc_q < -lim_val) begin
					alu_raw = -lim_val;
				end else begin
					alu_raw = acc_q;
				end
			end
			default:  alu_raw = acc_q;
		endcase
	end

	assign alu_sat = sat32(alu_raw);

	always_comb begin
		if (ctrl.sat) begin
			acc_next = {{(SUM_W-DATA_W){alu_sat[DATA_W-1]}}, alu_sat};
		end else begin
			acc_next = alu_raw;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_q <= measured_position;
			spd_q <= measured_speed;
			tgt_q <= target_position;
		end
		if (en) begin
			acc_q <= acc_next;
			if (ctrl.mul_en) begin
				prod_q <= prod_full[PROD_W-1:0];
			end
			case (ctrl.pacc)
				P_LOAD:  psum_q <= prod_ext;
				P_ADD:   psum_q <= psum_sum;
				P_ADDS:  psum_q <= {{(SUM_W-DATA_W){psum_sat[DATA_W-1]}}, psum_sat};
				default: psum_q <= psum_q;
			endcase
			case (ctrl.dst)
				DST_E:   e_q <= acc_next[DATA_W-1:0];
				DST_D:   d_q <= acc_next[DATA_W-1:0];
				DST_CMD: cmd_q <= acc_next[DATA_W-1:0];
				DST_VE:  ve_q <= acc_next[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ole_q  <= '0;
			osum_q <= '0;
			ile_q  <= '0;
			ipe_q  <= '0;
			iacc_q <= '0;
		end else if (en) begin
			case (ctrl.dst)
				DST_OLE:  ole_q <= acc_next[DATA_W-1:0];
				DST_OSUM: osum_q <= acc_next[DATA_W-1:0];
				DST_ILE:  ile_q <= acc_next[DATA_W-1:0];
				DST_IPE:  ipe_q <= acc_next[DATA_W-1:0];
				DST_IACC: iacc_q <= acc_next[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	assign speed_cmd = cmd_q;
	assign torque_next = acc_next[DATA_W-1:0];

endmodule

// File: rtl/cascaded_position_speed_pid_core.sv
// Top level of the cascaded position and speed PID core: configuration registers,
// microprogram sequencer and output register. Depends on cpsp_pkg and cpsp_datapath.
//
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    measured_position, measured_speed, target_position
// out       output     out_valid / out_stall  speed_command, torque_command
// cfg       input      cfg_write_en           cfg_index, cfg_data
//
// Each request runs an 18-step microprogram, one step per cycle unless the last step is held,
// through one shared multiplier and one accumulator; no new request is taken while it runs.
// The next request is taken in the cycle in which the last step completes.
// A result waiting in the output register holds the last step until it is taken.
// Reset clears the loop state and loads the default gains and limits.
module cascaded_position_speed_pid_core import cpsp_pkg::*; #(
	parameter int ERR_SUM_BOUND = ERR_SUM_BOUND_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] measured_position,
	input  logic signed [DATA_W-1:0] measured_speed,
	input  logic signed [DATA_W-1:0] target_position,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] speed_command,
	output logic signed [DATA_W-1:0] torque_command,
	input  logic                     cfg_write_en,
	input  logic [2:0]               cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data
);

	cfg_t                     cfg_q;
	logic                     busy_q;
	logic [STEP_W-1:0]        step_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] speed_command_q, torque_command_q;

	ucode_t                   ctrl;
	logic                     accept, end_fire, word_en, hold_end;
	logic signed [DATA_W-1:0] speed_cmd, torque_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outer_kp     <= RST_OUTER_KP;
			cfg_q.outer_ki     <= RST_OUTER_KI;
			cfg_q.outer_kd     <= RST_OUTER_KD;
			cfg_q.inner_kp     <= RST_INNER_KP;
			cfg_q.inner_ki     <= RST_INNER_KI;
			cfg_q.inner_kd     <= RST_INNER_KD;
			cfg_q.speed_limit  <= RST_SPEED_LIMIT;
			cfg_q.torque_limit <= RST_TORQUE_LIMIT;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_OUTER_KP:     cfg_q.outer_kp <= cfg_data;
				REG_OUTER_KI:     cfg_q.outer_ki <= cfg_data;
				REG_OUTER_KD:     cfg_q.outer_kd <= cfg_data;
				REG_INNER_KP:     cfg_q.inner_kp <= cfg_data;
				REG_INNER_KI:     cfg_q.inner_ki <= cfg_data;
				REG_INNER_KD:     cfg_q.inner_kd <= cfg_data;
				REG_SPEED_LIMIT:  cfg_q.speed_limit <= cfg_data;
				REG_TORQUE_LIMIT: cfg_q.torque_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ctrl     = ucode_rom(step_q);
	assign hold_end = (ctrl.seq == SEQ_END) && out_valid_q && out_stall;
	assign word_en  = busy_q && !hold_end;
	assign end_fire = word_en && (ctrl.seq == SEQ_END);
	assign in_stall = busy_q && !end_fire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (end_fire) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else if (word_en) begin
				step_q <= step_q + 1'b1;
			end
			if (end_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire) begin
			speed_command_q  <= speed_cmd;
			torque_command_q <= torque_next;
		end
	end

	cpsp_datapath #(
		.ERR_SUM_BOUND(ERR_SUM_BOUND)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.ctrl              (ctrl),
		.en                (word_en),
		.load              (accept),
		.measured_position (measured_position),
		.measured_speed    (measured_speed),
		.target_position   (target_position),
		.speed_cmd         (speed_cmd),
		.torque_next       (torque_next)
	);

	assign out_valid      = out_valid_q;
	assign speed_command  = speed_command_q;
	assign torque_command = torque_command_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && step_q == '0))
		else $error("accepted request did not start the program at its first step");

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(end_fire))
		else $error("result appeared without the last step completing");

	a_idle_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (step_q == '0))
		else $error("step counter moved while idle");

	a_step_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q < STEP_W'(UCODE_LEN)))
		else $error("step counter ran past the end of the program");

endmodule

// File: tb/sv/tb_cascaded_position_speed_pid_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for cascaded_position_speed_pid_core: a predictor of both control
// loops checks every speed and torque command, under random idling and back-pressure.
// Depends on cpsp_pkg and the RTL of the core only.
module tb_cascaded_position_speed_pid_core;
	import cpsp_pkg::*;

	localparam int INT_LIMIT = 1000;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;
	localparam longint W_MAX = 64'sd2147483647;
	localparam longint W_MIN = -64'sd2147483648;
	localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 31'h7fff_ffff;

	typedef enum logic {STALL_NONE, STALL_RANDOM} stall_style_t;

	typedef struct {
		logic signed [DATA_W-1:0] speed;
		logic signed [DATA_W-1:0] torque;
	} cmd_pair_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DATA_W-1:0] measured_position = '0;
	logic signed [DATA_W-1:0] measured_speed = '0;
	logic signed [DATA_W-1:0] target_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] speed_command;
	logic signed [DATA_W-1:0] torque_command;
	logic cfg_write_en = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;

	cfg_t gains = '{RST_OUTER_KP, RST_OUTER_KI, RST_OUTER_KD, RST_INNER_KP, RST_INNER_KI,
		RST_INNER_KD, RST_SPEED_LIMIT, RST_TORQUE_LIMIT};
	longint pos_last_err = 0;
	longint pos_err_sum = 0;
	longint spd_last_err = 0;
	longint spd_prev_err = 0;
	longint torque_acc = 0;

	cmd_pair_t expected_cmds[$];
	int mismatches = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int settings_loaded = 0;
	int idle_cycles = 0;
	bit hold_request = 1'b0;
	bit sender_gaps = 1'b1;
	stall_style_t stall_style = STALL_RANDOM;

	cascaded_position_speed_pid_core #(
		.ERR_SUM_BOUND(INT_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.measured_position(measured_position),
		.measured_speed(measured_speed),
		.target_position(target_position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.speed_command(speed_command),
		.torque_command(torque_command),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint sat32(longint v);
		if (v > W_MAX) return W_MAX;
		if (v < W_MIN) return W_MIN;
		return v;
	endfunction

	// Unsigned Q15.16 gain times a 32-bit value, floored and saturated.
	function automatic longint gain_mul(logic [GAIN_W-1:0] g, longint x);
		longint gl;
		gl = longint'(g);
		return sat32((gl * x) >>> FRAC_BITS);
	endfunction

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		return v;
	endfunction

	function automatic cmd_pair_t pid_tick(logic signed [DATA_W-1:0] pos,
		logic signed [DATA_W-1:0] spd, logic signed [DATA_W-1:0] tgt);
		longint e, p, i, d, cmd, ve, vp, vi, vd, inc;
		cmd_pair_t r;
		e = sat32(longint'(tgt) - longint'(pos));
		p = gain_mul(gains.outer_kp, e);
		i = gain_mul(gains.outer_ki, pos_err_sum);
		d = gain_mul(gains.outer_kd, sat32(e - pos_last_err));
		cmd = sat32(sat32(p + i) + d);
		pos_last_err = e;
		pos_err_sum = clamp_sym(sat32(pos_err_sum + e), longint'(INT_LIMIT) * 65536);
		cmd = clamp_sym(cmd, longint'(gains.speed_limit));
		ve = sat32(cmd - longint'(spd));
		vp = gain_mul(gains.inner_kp, sat32(ve - spd_last_err));
		vi = gain_mul(gains.inner_ki, ve);
		vd = gain_mul(gains.inner_kd, sat32(ve - 2 * spd_last_err + spd_prev_err));
		inc = sat32(vp + vi + vd);
		torque_acc = sat32(torque_acc + inc);
		spd_prev_err = spd_last_err;
		spd_last_err = ve;
		torque_acc = clamp_sym(torque_acc, longint'(gains.torque_limit));
		r.speed = cmd[31:0];
		r.torque = torque_acc[31:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 16);
		return $urandom_range(17, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_small(int bits);
		return $signed($urandom) >>> (33 - bits);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return S_MIN;
					1: return S_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2, 3, 4: return $urandom;
			default: return rand_small($urandom_range(4, 24));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return GAIN_MAX;
			2, 3: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(0, 1 << 20));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_limit();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return GAIN_MAX;
			2, 3, 4: return GAIN_W'($urandom);
			default: return GAIN_W'($urandom_range(1 << 12, 1 << 24));
		endcase
	endfunction

	function automatic cfg_t rand_setting();
		cfg_t c;
		c.outer_kp = rand_gain();
		c.outer_ki = rand_gain();
		c.outer_kd = rand_gain();
		c.inner_kp = rand_gain();
		c.inner_ki = rand_gain();
		c.inner_kd = rand_gain();
		c.speed_limit = rand_limit();
		c.torque_limit = rand_limit();
		return c;
	endfunction

	// Results are checked before the request of the same edge is predicted.
	always @(posedge clk) begin
		cmd_pair_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_cmds.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected result speed %0d torque %0d", $time,
							speed_command, torque_command);
				end else begin
					want = expected_cmds.pop_front();
					if (speed_command !== want.speed || torque_command !== want.torque) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: expected speed %0d torque %0d, got speed %0d torque %0d",
								$time, want.speed, want.torque, speed_command, torque_command);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_cmds.push_back(pid_tick(measured_position, measured_speed,
					target_position));
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: random stalls, no stalls, or one long hold when asked for.
	initial begin
		int run;
		run = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (stall_style == STALL_NONE) begin
				run = 0;
				out_stall <= 1'b0;
			end else begin
				if (run == 0 && $urandom_range(0, 3) == 0) run = pick_gap();
				out_stall <= (run > 0);
				if (run > 0) run--;
			end
		end
	end

	task automatic send_tick(input logic signed [DATA_W-1:0] pos,
		input logic signed [DATA_W-1:0] spd, input logic signed [DATA_W-1:0] tgt);
		int gap;
		measured_position <= pos;
		measured_speed <= spd;
		target_position <= tgt;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (results_seen < requests_sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic [GAIN_W-1:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		wait_idle();
		put_reg(REG_OUTER_KP, c.outer_kp);
		put_reg(REG_OUTER_KI, c.outer_ki);
		put_reg(REG_OUTER_KD, c.outer_kd);
		put_reg(REG_INNER_KP, c.inner_kp);
		put_reg(REG_INNER_KI, c.inner_ki);
		put_reg(REG_INNER_KD, c.inner_kd);
		put_reg(REG_SPEED_LIMIT, c.speed_limit);
		put_reg(REG_TORQUE_LIMIT, c.torque_limit);
		cfg_write_en <= 1'b0;
		gains = c;
		settings_loaded++;
	endtask

	// Mostly smooth shaft trajectories with occasional new set points, mixed with noise.
	task automatic random_ticks(input int count);
		logic signed [DATA_W-1:0] pos, spd, tgt;
		pos = rand_small(24);
		tgt = rand_small(24);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 15) == 0) tgt = rand_small(24);
				spd = rand_small(20);
				pos = pos + (spd >>> 6);
				send_tick(pos, spd, tgt);
			end else begin
				send_tick(rand_word(), rand_word(), rand_word());
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_tick(0, 0, 32'sd3 <<< 16);
		send_tick(32'sd1 <<< 16, 32'sd5 <<< 16, 0);
		send_tick(-(32'sd1 <<< 16), -(32'sd3 <<< 16), 32'sd1 <<< 16);
	endtask

	task automatic test_field_extremes();
		load_settings('{31'd65536, 31'd4096, 31'd16384, 31'd65536, 31'd1024, 31'd4096,
			GAIN_MAX, GAIN_MAX});
		send_tick(S_MIN, 0, S_MAX);
		send_tick(S_MAX, S_MAX, S_MIN);
		send_tick(0, S_MIN, 0);
		send_tick('1, '1, '1);
		send_tick(S_MAX, S_MIN, S_MAX);
		send_tick(S_MIN, S_MAX, S_MIN);
		send_tick(0, 0, 0);
	endtask

	task automatic test_zero_limits();
		load_settings('{31'd65536, 31'd4096, 31'd16384, 31'd65536, 31'd1024, 31'd4096,
			31'd0, 31'd0});
		send_tick(0, 32'sd1000, 32'sd5 <<< 16);
		send_tick(S_MIN, S_MIN, S_MAX);
		send_tick(32'sd1 <<< 20, -(32'sd1 <<< 20), 0);
	endtask

	// The error sum runs into the integral bound in both directions.
	task automatic test_integral_clamp();
		load_settings('{31'd0, 31'd65536, 31'd0, RST_INNER_KP, RST_INNER_KI, RST_INNER_KD,
			GAIN_MAX, RST_TORQUE_LIMIT});
		repeat (4) send_tick(0, 0, 32'sd300 <<< 16);
		send_tick(S_MAX, 0, S_MIN);
		send_tick(0, 0, 0);
	endtask

	task automatic test_gain_extremes();
		load_settings('{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX,
			GAIN_MAX, GAIN_MAX});
		send_tick(0, 0, 32'sd1);
		send_tick(0, 0, S_MAX);
		send_tick(S_MAX, S_MIN, S_MIN);
	endtask

	// The receiver holds off while requests keep coming, then the sender waits for all results.
	task automatic test_backpressure();
		load_settings(rand_setting());
		stall_style = STALL_RANDOM;
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		random_ticks(40);
		sender_gaps = 1'b1;
		wait_idle();
		random_ticks(20);
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 10; phase++) begin
			load_settings(rand_setting());
			sender_gaps = (phase % 4 != 3);
			stall_style = (phase % 4 == 3) ? STALL_NONE : STALL_RANDOM;
			random_ticks(117);
		end
		sender_gaps = 1'b1;
		stall_style = STALL_RANDOM;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_zero_limits();
		test_integral_clamp();
		test_gain_extremes();
		test_backpressure();
		test_random_settings();
		wait_idle();
		repeat (40) @(posedge clk);
		if (expected_cmds.size() != 0) begin
			$display("%0d expected commands never arrived", expected_cmds.size());
			mismatches += expected_cmds.size();
		end
		$display("Covered %0d requests and %0d results over %0d register settings,",
			requests_sent, results_seen, settings_loaded);
		$display("including saturation, zero limits, integral bounds and a long output hold.");
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
